FILE: rtl/core/kds_pkg.sv
// kick drum voice: shared types, codes and fixed-point constants
// no dependencies; the top level, multiplier and divider import this package
package kds_pkg;

    localparam int MUL_A_W = 38;
    localparam int MUL_B_W = 19;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    localparam int DIV_N_W = 53;
    localparam int DIV_D_W = 38;
    localparam int DIV_Q_W = 17;

    localparam int NOTE_COUNT = 128;

    localparam logic [15:0] ONE_Q15       = 16'd32768;
    localparam logic [16:0] TONE_ON_MIN   = 17'd3276;
    localparam logic [16:0] DRIVE_ON_MIN  = 17'd328;
    localparam logic [16:0] CLICK_GATE    = 17'd32;
    localparam logic [16:0] ENV_STOP      = 17'd4;
    localparam logic [16:0] SIN_C0        = 17'd51472;
    localparam logic [16:0] SIN_C1        = 17'd21167;
    localparam logic [16:0] SIN_C2        = 17'd2611;
    localparam logic [16:0] H2_WEIGHT     = 17'd9830;
    localparam logic [16:0] H3_WEIGHT     = 17'd3277;
    localparam logic [34:0] TANH_K        = 35'd28991029248;
    localparam logic [3:0]  TANH_TT_MUL   = 4'd9;
    localparam logic [15:0] Q15_MAX       = 16'd32767;
    localparam logic [6:0]  VEL_STEP_LO   = 7'd32;
    localparam logic [6:0]  VEL_STEP_HI   = 7'd96;
    localparam logic [31:0] LFSR_SEED     = 32'h0000ACE1;
    localparam logic [31:0] LFSR_MASK     = 32'h80200003;
    localparam logic [23:0] INC_MAX       = 24'hFFFFFF;

    localparam logic [19:0] BASE_FREQ_Q16 [12] = '{
        20'd535809, 20'd567670, 20'd601425, 20'd637188, 20'd675077, 20'd715219,
        20'd757749, 20'd802807, 20'd850544, 20'd901120, 20'd954703, 20'd1011473
    };

    typedef logic [23:0] note_tab_t [NOTE_COUNT];

    typedef enum logic {
        OP_TICK    = 1'b0,
        OP_TRIGGER = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        CFG_GLIDE       = 3'd0,
        CFG_ENV_DECAY   = 3'd1,
        CFG_CLICK_DECAY = 3'd2,
        CFG_CLICK_AMT   = 3'd3,
        CFG_TONE        = 3'd4,
        CFG_DRIVE       = 3'd5,
        CFG_FILTER      = 3'd6,
        CFG_GLIDE_START = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic               start;
        logic [DIV_N_W-1:0] num;
        logic [DIV_D_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic [DIV_Q_W-1:0] quot;
    } div_rsp_t;

    function automatic logic [16:0] clamp_one(logic [15:0] v);
        return (v > ONE_Q15) ? 17'(ONE_Q15) : 17'(v);
    endfunction

endpackage

FILE: rtl/core/kds_if.sv
// kick drum voice: command, audio and configuration channel interfaces
// no dependencies
interface kds_cmd_if;
    logic       valid;
    logic       ready;
    logic [0:0] operation;
    logic [6:0] note;
    logic [6:0] velocity;
    modport source (output valid, output operation, output note, output velocity, input ready);
    modport sink (input valid, input operation, input note, input velocity, output ready);
endinterface

interface kds_audio_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] sample;
    modport source (output valid, output sample, input ready);
    modport sink (input valid, input sample, output ready);
endinterface

interface kds_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

FILE: rtl/core/kick_drum_synth_voice.sv
// kick drum voice top level: command decode, sequencer, state and configuration
// depends on kds_pkg, kds_if, kds_mul and kds_div
//
// One command at a time. A trigger loads pitch (note table), the start
// increment (target times glide_start_reg), velocity gain (258 times the
// velocity plus rounding steps), envelope, click and phase, and returns
// nothing. A tick returns one sample: 0 when the voice is idle, otherwise
// the result of glide, sine, envelope, lowpass and velocity gain, with the
// harmonics when they are on, the click while it is gated in and drive
// through the tanh curve when drive is on (full scale when the driven level
// is past the tanh range). Every product of the sample goes through the
// single shared multiplier in turn, and the 17-step divider serves the tanh
// curve.
// cmd.ready is high only between commands; a finished sample sits in an
// output register, so the next command is taken while it waits.
// Configuration writes are always ready and must come while the voice is
// between commands.
module kick_drum_synth_voice #(
    parameter int SAMPLE_RATE_HZ  = 48000,
    parameter int SINE_TABLE_BITS = 10,
    parameter int TANH_TABLE_BITS = 10
) (
    input  logic        clk,
    input  logic        rst_n,
    kds_cmd_if.sink     cmd,
    kds_audio_if.source audio,
    kds_cfg_if.sink     cfg
);
    import kds_pkg::*;

    localparam int SB = SINE_TABLE_BITS;
    localparam int ZS = 17 - SINE_TABLE_BITS;
    localparam int TS = 17 - TANH_TABLE_BITS;

    // phase increment per note, rounded, built at elaboration
    function automatic note_tab_t note_tab_build();
        note_tab_t         tab;
        longint unsigned   f;
        longint unsigned   inc;
        for (int n = 0; n < NOTE_COUNT; n++)
        begin
            f   = longint'(BASE_FREQ_Q16[n % 12]) << (n / 12);
            inc = (f * 256 + SAMPLE_RATE_HZ / 2) / SAMPLE_RATE_HZ;
            tab[n] = (inc > longint'(INC_MAX)) ? INC_MAX : inc[23:0];
        end
        return tab;
    endfunction

    localparam note_tab_t NOTE_INC = note_tab_build();

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_TRIG_MUL,
        ST_TRIG_CUR,
        ST_TRIG_WAIT,
        ST_GLIDE_A,
        ST_GLIDE_B,
        ST_GLIDE_C,
        ST_SIN_Z,
        ST_SIN_Z2,
        ST_SIN_T1,
        ST_SIN_T2,
        ST_SIN_Y,
        ST_HARM_MUL,
        ST_HARM_ACC,
        ST_ENV_MUL,
        ST_ENV_DEC,
        ST_ENV_SET,
        ST_CLICK_MUL,
        ST_CLICK_ACC,
        ST_CLICK_DEC,
        ST_DRIVE_MUL,
        ST_DRIVE_SQ,
        ST_DRIVE_NUM,
        ST_DRIVE_DEN,
        ST_DRIVE_DIV,
        ST_DRIVE_WAIT,
        ST_FILT_MUL,
        ST_FILT_ACC,
        ST_OUT_CALC,
        ST_OUT
    } state_t;

    // configuration registers
    logic [15:0] glide_reg, env_dec_reg, click_dec_reg, click_amt_reg;
    logic [15:0] tone_reg, drive_reg, filt_coef_reg, glide_start_reg;

    // voice state
    state_t             state_reg;
    logic [23:0]        phase_reg, cur_reg, tgt_reg;
    logic [16:0]        env_reg, click_reg;
    logic [15:0]        vel_gain_reg;
    logic signed [23:0] filt_reg;
    logic               active_reg;
    logic [31:0]        lfsr_reg;

    // sequencer scratch
    logic signed [19:0] acc_reg;
    logic [40:0]        w_reg;
    logic [16:0]        z_reg, z2_reg, tq_reg;
    logic [1:0]         quad_reg, harm_reg;
    logic               neg_reg;
    logic [33:0]        tt_reg;
    logic [DIV_N_W-1:0] num_reg;
    logic signed [15:0] res_reg, sample_reg;
    logic               out_valid_reg;

    // shared units
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_P_W-1:0] mul_p;
    logic signed [MUL_P_W-1:0] mul_sh15;
    div_req_t                  div_req;
    div_rsp_t                  div_rsp;

    kds_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    kds_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // clamped levels and switches
    logic [16:0] glide_c, env_dec_c, click_dec_c, click_amt_c, tone_c, drive_c, filt_c;
    logic [16:0] glide_inv;
    logic [17:0] drive_gain;
    logic        tone_on, drive_on, cmd_accept;

    assign glide_c     = clamp_one(glide_reg);
    assign env_dec_c   = clamp_one(env_dec_reg);
    assign click_dec_c = clamp_one(click_dec_reg);
    assign click_amt_c = clamp_one(click_amt_reg);
    assign tone_c      = clamp_one(tone_reg);
    assign drive_c     = clamp_one(drive_reg);
    assign filt_c      = clamp_one(filt_coef_reg);
    assign glide_inv   = 17'(ONE_Q15) - glide_c;
    assign drive_gain  = 18'(ONE_Q15) + 18'({drive_c, 2'b00}) + 18'(drive_c);
    assign tone_on     = tone_c > TONE_ON_MIN;
    assign drive_on    = drive_c >= DRIVE_ON_MIN;
    assign cmd_accept  = cmd.valid && cmd.ready;

    assign mul_sh15 = mul_p >>> 15;

    // sine argument: phase, twice or three times the phase
    logic [23:0]        sin_ph;
    logic [SB-1:0]      sin_idx;
    logic [16:0]        z_raw, z_val;
    logic [16:0]        y_mag;
    logic signed [16:0] y_pos, y_sin;

    always_comb
    begin
        unique case (harm_reg)
            2'd0:    sin_ph = phase_reg;
            2'd1:    sin_ph = {phase_reg[22:0], 1'b0};
            default: sin_ph = phase_reg + {phase_reg[22:0], 1'b0};
        endcase
    end

    assign sin_idx = sin_ph[23 -: SB];
    assign z_raw   = 17'({sin_idx[SB-3:0], {ZS{1'b0}}});
    assign z_val   = sin_idx[SB-2] ? (17'(ONE_Q15) - z_raw) : z_raw;
    assign y_mag   = mul_sh15[16:0];
    assign y_pos   = (y_mag > 17'(Q15_MAX)) ? 17'(Q15_MAX) : signed'(y_mag);
    assign y_sin   = quad_reg[1] ? -y_pos : y_pos;

    // tanh argument magnitude, cut to the table grid
    logic signed [21:0] tanh_x;
    logic [21:0]        tanh_m;
    logic               tanh_big;
    logic [16:0]        tanh_t;
    logic [15:0]        tanh_y;

    assign tanh_x   = 22'(mul_sh15);
    assign tanh_m   = tanh_x[21] ? 22'(-tanh_x) : 22'(tanh_x);
    assign tanh_big = tanh_m[21:17] != '0;
    assign tanh_t   = {tanh_m[16:TS], {TS{1'b0}}};
    assign tanh_y   = (div_rsp.quot > DIV_Q_W'(Q15_MAX)) ? Q15_MAX : div_rsp.quot[15:0];

    // misc datapath values
    logic [31:0]        lfsr_next;
    logic [40:0]        glide_sum;
    logic signed [23:0] filt_new;
    logic signed [24:0] filt_diff;
    logic [15:0]        out_sat;

    assign lfsr_next = lfsr_reg[0] ? ((lfsr_reg >> 1) ^ LFSR_MASK) : (lfsr_reg >> 1);
    assign glide_sum = w_reg + 41'(mul_p);
    assign filt_new  = filt_reg + 24'(mul_sh15);
    assign filt_diff = 25'(acc_reg) - 25'(filt_reg);

    always_comb
    begin
        priority if (mul_sh15 > MUL_P_W'(signed'({1'b0, Q15_MAX})))
            out_sat = Q15_MAX;
        else if (mul_sh15 < -MUL_P_W'(signed'({1'b0, ONE_Q15})))
            out_sat = ONE_Q15;
        else
            out_sat = mul_sh15[15:0];
    end

    // divider request: tanh quotient in the drive steps
    always_comb
    begin
        div_req.start = (state_reg == ST_DRIVE_DIV);
        div_req.num   = num_reg;
        div_req.den   = DIV_D_W'(TANH_K) + mul_p[DIV_D_W-1:0];
    end

    // multiplier operand select, product used in the following state
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_TRIG_MUL:
            begin
                mul_a = MUL_A_W'(tgt_reg);
                mul_b = MUL_B_W'(glide_start_reg);
            end
            ST_GLIDE_A:
            begin
                mul_a = MUL_A_W'(cur_reg);
                mul_b = MUL_B_W'(glide_c);
            end
            ST_GLIDE_B:
            begin
                mul_a = MUL_A_W'(tgt_reg);
                mul_b = MUL_B_W'(glide_inv);
            end
            ST_SIN_Z:
            begin
                mul_a = MUL_A_W'(z_val);
                mul_b = MUL_B_W'(z_val);
            end
            ST_SIN_Z2:
            begin
                mul_a = MUL_A_W'(mul_p[31:15]);
                mul_b = MUL_B_W'(SIN_C2);
            end
            ST_SIN_T1:
            begin
                mul_a = MUL_A_W'(z2_reg);
                mul_b = MUL_B_W'(SIN_C1 - mul_p[31:15]);
            end
            ST_SIN_T2:
            begin
                mul_a = MUL_A_W'(z_reg);
                mul_b = MUL_B_W'(SIN_C0 - mul_p[31:15]);
            end
            ST_SIN_Y:
            begin
                mul_a = MUL_A_W'(y_sin);
                mul_b = MUL_B_W'(tone_c);
            end
            ST_HARM_MUL:
            begin
                mul_a = MUL_A_W'(mul_p);
                mul_b = (harm_reg == 2'd1) ? MUL_B_W'(H2_WEIGHT) : MUL_B_W'(H3_WEIGHT);
            end
            ST_ENV_MUL:
            begin
                mul_a = MUL_A_W'(acc_reg);
                mul_b = MUL_B_W'(env_reg);
            end
            ST_ENV_DEC:
            begin
                mul_a = MUL_A_W'(env_reg);
                mul_b = MUL_B_W'(env_dec_c);
            end
            ST_CLICK_MUL:
            begin
                mul_a = MUL_A_W'(signed'(lfsr_reg[15:0]));
                mul_b = MUL_B_W'(click_reg);
            end
            ST_CLICK_ACC:
            begin
                mul_a = MUL_A_W'(click_reg);
                mul_b = MUL_B_W'(click_dec_c);
            end
            ST_DRIVE_MUL:
            begin
                mul_a = MUL_A_W'(acc_reg);
                mul_b = MUL_B_W'(drive_gain);
            end
            ST_DRIVE_SQ:
            begin
                mul_a = MUL_A_W'(tanh_t);
                mul_b = MUL_B_W'(tanh_t);
            end
            ST_DRIVE_NUM:
            begin
                mul_a = MUL_A_W'(TANH_K) + MUL_A_W'(mul_p[33:0]);
                mul_b = MUL_B_W'(tq_reg);
            end
            ST_DRIVE_DEN:
            begin
                mul_a = MUL_A_W'(tt_reg);
                mul_b = MUL_B_W'(TANH_TT_MUL);
            end
            ST_FILT_MUL:
            begin
                mul_a = MUL_A_W'(filt_diff);
                mul_b = MUL_B_W'(filt_c);
            end
            ST_FILT_ACC:
            begin
                mul_a = MUL_A_W'(filt_new);
                mul_b = MUL_B_W'(vel_gain_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            glide_reg       <= 16'd0;
            env_dec_reg     <= 16'd32760;
            click_dec_reg   <= 16'd31436;
            click_amt_reg   <= 16'd16384;
            tone_reg        <= 16'd0;
            drive_reg       <= 16'd0;
            filt_coef_reg   <= 16'd16384;
            glide_start_reg <= 16'd8192;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg_idx_t'(cfg.index))
                CFG_GLIDE:       glide_reg       <= cfg.data;
                CFG_ENV_DECAY:   env_dec_reg     <= cfg.data;
                CFG_CLICK_DECAY: click_dec_reg   <= cfg.data;
                CFG_CLICK_AMT:   click_amt_reg   <= cfg.data;
                CFG_TONE:        tone_reg        <= cfg.data;
                CFG_DRIVE:       drive_reg       <= cfg.data;
                CFG_FILTER:      filt_coef_reg   <= cfg.data;
                CFG_GLIDE_START: glide_start_reg <= cfg.data;
            endcase
        end
    end

    // sequencer, voice state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= '0;
            cur_reg       <= '0;
            tgt_reg       <= '0;
            env_reg       <= '0;
            click_reg     <= '0;
            vel_gain_reg  <= '0;
            filt_reg      <= '0;
            active_reg    <= 1'b0;
            lfsr_reg      <= LFSR_SEED;
            acc_reg       <= '0;
            w_reg         <= '0;
            z_reg         <= '0;
            z2_reg        <= '0;
            tq_reg        <= '0;
            quad_reg      <= '0;
            harm_reg      <= '0;
            neg_reg       <= 1'b0;
            tt_reg        <= '0;
            num_reg       <= '0;
            res_reg       <= '0;
            sample_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // ST_OUT does its own handshake bookkeeping below
            if (out_valid_reg && audio.ready && (state_reg != ST_OUT))
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (cmd_accept)
                    begin
                        if (cmd.operation == OP_TRIGGER)
                        begin
                            tgt_reg      <= NOTE_INC[cmd.note];
                            // velocity * 32768 / 127 rounded: 258 v plus a step
                            // at 32 and another at 96
                            vel_gain_reg <= 16'({cmd.velocity, 8'd0})
                                          + 16'({cmd.velocity, 1'b0})
                                          + 16'(cmd.velocity >= VEL_STEP_LO)
                                          + 16'(cmd.velocity >= VEL_STEP_HI);
                            state_reg    <= ST_TRIG_MUL;
                        end
                        else if (!active_reg)
                        begin
                            // idle voice: silent sample, state untouched
                            res_reg   <= '0;
                            state_reg <= ST_OUT;
                        end
                        else
                        begin
                            state_reg <= ST_GLIDE_A;
                        end
                    end
                end
                ST_TRIG_MUL:
                begin
                    state_reg <= ST_TRIG_CUR;
                end
                ST_TRIG_CUR:
                begin
                    // start increment saturates at full scale
                    cur_reg   <= (mul_p[MUL_P_W-1:37] != '0) ? INC_MAX : mul_p[36:13];
                    state_reg <= ST_TRIG_WAIT;
                end
                ST_TRIG_WAIT:
                begin
                    env_reg    <= 17'(ONE_Q15);
                    click_reg  <= click_amt_c;
                    phase_reg  <= '0;
                    active_reg <= 1'b1;
                    state_reg  <= ST_IDLE;
                end
                ST_GLIDE_A:
                begin
                    state_reg <= ST_GLIDE_B;
                end
                ST_GLIDE_B:
                begin
                    w_reg     <= mul_p[40:0];
                    state_reg <= ST_GLIDE_C;
                end
                ST_GLIDE_C:
                begin
                    cur_reg   <= glide_sum[38:15];
                    harm_reg  <= 2'd0;
                    state_reg <= ST_SIN_Z;
                end
                ST_SIN_Z:
                begin
                    z_reg     <= z_val;
                    quad_reg  <= sin_idx[SB-1 -: 2];
                    state_reg <= ST_SIN_Z2;
                end
                ST_SIN_Z2:
                begin
                    z2_reg    <= mul_p[31:15];
                    state_reg <= ST_SIN_T1;
                end
                ST_SIN_T1:
                begin
                    state_reg <= ST_SIN_T2;
                end
                ST_SIN_T2:
                begin
                    state_reg <= ST_SIN_Y;
                end
                ST_SIN_Y:
                begin
                    if (harm_reg == 2'd0)
                    begin
                        acc_reg <= 20'(y_sin);
                        if (tone_on)
                        begin
                            harm_reg  <= 2'd1;
                            state_reg <= ST_SIN_Z;
                        end
                        else
                        begin
                            state_reg <= ST_ENV_MUL;
                        end
                    end
                    else
                    begin
                        state_reg <= ST_HARM_MUL;
                    end
                end
                ST_HARM_MUL:
                begin
                    state_reg <= ST_HARM_ACC;
                end
                ST_HARM_ACC:
                begin
                    acc_reg <= acc_reg + 20'(mul_p >>> 30);
                    if (harm_reg == 2'd1)
                    begin
                        harm_reg  <= 2'd2;
                        state_reg <= ST_SIN_Z;
                    end
                    else
                    begin
                        state_reg <= ST_ENV_MUL;
                    end
                end
                ST_ENV_MUL:
                begin
                    phase_reg <= phase_reg + cur_reg;
                    state_reg <= ST_ENV_DEC;
                end
                ST_ENV_DEC:
                begin
                    acc_reg   <= 20'(mul_sh15);
                    state_reg <= ST_ENV_SET;
                end
                ST_ENV_SET:
                begin
                    env_reg <= mul_p[31:15];
                    // click noise only while its level is above the gate
                    if (click_reg > CLICK_GATE)
                    begin
                        lfsr_reg  <= lfsr_next;
                        state_reg <= ST_CLICK_MUL;
                    end
                    else
                    begin
                        state_reg <= ST_DRIVE_MUL;
                    end
                end
                ST_CLICK_MUL:
                begin
                    state_reg <= ST_CLICK_ACC;
                end
                ST_CLICK_ACC:
                begin
                    acc_reg   <= acc_reg + 20'(mul_sh15);
                    state_reg <= ST_CLICK_DEC;
                end
                ST_CLICK_DEC:
                begin
                    click_reg <= mul_p[31:15];
                    state_reg <= ST_DRIVE_MUL;
                end
                ST_DRIVE_MUL:
                begin
                    state_reg <= drive_on ? ST_DRIVE_SQ : ST_FILT_MUL;
                end
                ST_DRIVE_SQ:
                begin
                    neg_reg <= tanh_x[21];
                    tq_reg  <= tanh_t;
                    if (tanh_big)
                    begin
                        // beyond the curve's range: full scale
                        acc_reg   <= tanh_x[21] ? -20'(Q15_MAX) : 20'(Q15_MAX);
                        state_reg <= ST_FILT_MUL;
                    end
                    else
                    begin
                        state_reg <= ST_DRIVE_NUM;
                    end
                end
                ST_DRIVE_NUM:
                begin
                    tt_reg    <= mul_p[33:0];
                    state_reg <= ST_DRIVE_DEN;
                end
                ST_DRIVE_DEN:
                begin
                    num_reg   <= mul_p[DIV_N_W-1:0];
                    state_reg <= ST_DRIVE_DIV;
                end
                ST_DRIVE_DIV:
                begin
                    state_reg <= ST_DRIVE_WAIT;
                end
                ST_DRIVE_WAIT:
                begin
                    if (div_rsp.done)
                    begin
                        acc_reg   <= neg_reg ? -20'(tanh_y) : 20'(tanh_y);
                        state_reg <= ST_FILT_MUL;
                    end
                end
                ST_FILT_MUL:
                begin
                    state_reg <= ST_FILT_ACC;
                end
                ST_FILT_ACC:
                begin
                    filt_reg  <= filt_new;
                    state_reg <= ST_OUT_CALC;
                end
                ST_OUT_CALC:
                begin
                    res_reg <= signed'(out_sat);
                    // voice ends after the sample where the envelope dies out
                    if (env_reg < ENV_STOP)
                    begin
                        active_reg <= 1'b0;
                    end
                    state_reg <= ST_OUT;
                end
                ST_OUT:
                begin
                    if (!out_valid_reg || audio.ready)
                    begin
                        sample_reg    <= res_reg;
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign cmd.ready    = (state_reg == ST_IDLE);
    assign audio.valid  = out_valid_reg;
    assign audio.sample = sample_reg;
    assign cfg.ready    = 1'b1;

endmodule

FILE: rtl/core/kds_mul.sv
// kick drum voice: shared signed multiplier with registered product
// depends on kds_pkg
module kds_mul (
    input  logic                                 clk,
    input  logic signed [kds_pkg::MUL_A_W-1:0]   a,
    input  logic signed [kds_pkg::MUL_B_W-1:0]   b,
    output logic signed [kds_pkg::MUL_P_W-1:0]   p
);
    import kds_pkg::*;

    logic signed [MUL_P_W-1:0] p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= MUL_P_W'(a) * MUL_P_W'(b);
    end

    assign p = p_reg;

endmodule

FILE: rtl/core/kds_div.sv
// kick drum voice: restoring divider, one quotient bit per cycle
// depends on kds_pkg; the quotient must fit DIV_Q_W bits
module kds_div (
    input  logic                clk,
    input  logic                rst_n,
    input  kds_pkg::div_req_t   req,
    output kds_pkg::div_rsp_t   rsp
);
    import kds_pkg::*;

    localparam int CNT_W = $clog2(DIV_Q_W + 1);
    localparam int SH_W  = DIV_D_W + DIV_Q_W - 1;

    logic [DIV_N_W-1:0] rem_reg;
    logic [SH_W-1:0]    dsh_reg;
    logic [DIV_Q_W-1:0] quot_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               busy_reg;
    logic               done_reg;
    logic               fits;

    assign fits = SH_W'(rem_reg) >= dsh_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg  <= '0;
            dsh_reg  <= '0;
            quot_reg <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                rem_reg  <= req.num;
                dsh_reg  <= {req.den, {(DIV_Q_W-1){1'b0}}};
                quot_reg <= '0;
                cnt_reg  <= CNT_W'(DIV_Q_W);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                if (fits)
                begin
                    rem_reg <= DIV_N_W'(SH_W'(rem_reg) - dsh_reg);
                end
                quot_reg <= {quot_reg[DIV_Q_W-2:0], fits};
                dsh_reg  <= dsh_reg >> 1;
                cnt_reg  <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;

endmodule
